// ===== sv/fhist_pkg.sv =====
`default_nettype none

package fhist_pkg;

    localparam int BIN_COUNT_DEF = 8;
    localparam int LIMIT_REGS    = 7;
    localparam int LIMIT_W       = 14;
    localparam int CFG_IDX_W     = 3;
    localparam int FUNC_W        = 2;
    localparam int SIZE_W        = 15;
    localparam int BIN_NUM_W     = 3;
    localparam int IBYTES_W      = 32;
    localparam int IFRAMES_W     = 24;
    localparam int TBYTES_W      = 48;
    localparam int TFRAMES_W     = 40;

    localparam logic [LIMIT_W-1:0] LAST_LIMIT     = 14'd9999;
    localparam logic [SIZE_W-1:0]  FRAME_OVERHEAD = 15'd26;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET [LIMIT_REGS] = '{
        14'd60, 14'd100, 14'd128, 14'd256, 14'd512, 14'd1024, 14'd1200
    };

    typedef enum logic [FUNC_W-1:0] {
        FN_FRAME  = 2'd0,
        FN_STATUS = 2'd1,
        FN_REPORT = 2'd2,
        FN_SPARE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_UPDATE,
        ST_FOLD
    } state_t;

    typedef struct packed {
        logic load_in;
        logic classify;
        logic update;
        logic idx_clear;
        logic fold;
    } fhist_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic last_idx;
    } fhist_status_t;

endpackage

`default_nettype wire

// ===== sv/fhist_ctrl.sv =====
`default_nettype none

module fhist_ctrl
    import fhist_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [FUNC_W-1:0]   func,
    output logic                     in_stall,
    input  wire fhist_status_t       status,
    output fhist_cmd_t               cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    case (func_t'(func))
                        FN_FRAME:
                        begin
                            state_next = ST_CLASSIFY;
                        end
                        FN_REPORT:
                        begin
                            cmd.idx_clear = 1'b1;
                            state_next    = ST_FOLD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FOLD:
            begin
                if (!status.out_busy)
                begin
                    cmd.fold = 1'b1;
                    if (status.last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLASSIFY |=> state_reg == ST_UPDATE)
        else $error("classify not followed by update");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD && status.out_busy) |=> state_reg == ST_FOLD)
        else $error("report left while output stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken outside idle");
`endif

endmodule

`default_nettype wire

// ===== sv/fhist_datapath.sv =====
`default_nettype none

module fhist_datapath
    import fhist_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fhist_cmd_t            cmd,
    output fhist_status_t              status,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [LIMIT_W-1:0]    cfg_data,
    input  wire logic [LIMIT_W-1:0]    frame_length,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BIN_NUM_W-1:0]       bin_number,
    output logic [LIMIT_W-1:0]         lower_bound,
    output logic [LIMIT_W-1:0]         upper_bound,
    output logic [IBYTES_W-1:0]        interval_byte_count,
    output logic [IFRAMES_W-1:0]       interval_frame_count,
    output logic [TBYTES_W-1:0]        total_byte_count,
    output logic [TFRAMES_W-1:0]       total_frame_count,
    output logic                       last_bin
);

    localparam int IDX_W = $clog2(BIN_COUNT);

    logic [LIMIT_W-1:0]   limit_reg [LIMIT_REGS];
    logic [IBYTES_W-1:0]  ibytes_reg [BIN_COUNT];
    logic [IFRAMES_W-1:0] iframes_reg [BIN_COUNT];
    logic [TBYTES_W-1:0]  tbytes_reg [BIN_COUNT];
    logic [TFRAMES_W-1:0] tframes_reg [BIN_COUNT];

    logic [SIZE_W-1:0]  size_reg;
    logic [IDX_W-1:0]   bin_reg;
    logic [IDX_W-1:0]   bin_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [LIMIT_W-1:0] lower_reg;

    logic                  out_valid_reg;
    logic [BIN_NUM_W-1:0]  out_bin_reg;
    logic [LIMIT_W-1:0]    out_lower_reg;
    logic [LIMIT_W-1:0]    out_upper_reg;
    logic [IBYTES_W-1:0]   out_ibytes_reg;
    logic [IFRAMES_W-1:0]  out_iframes_reg;
    logic [TBYTES_W-1:0]   out_tbytes_reg;
    logic [TFRAMES_W-1:0]  out_tframes_reg;
    logic                  out_last_reg;

    logic [LIMIT_W-1:0]    upper [BIN_COUNT];
    logic [IDX_W-1:0]      ptr;
    logic [IBYTES_W-1:0]   ibytes_rd;
    logic [IFRAMES_W-1:0]  iframes_rd;
    logic [IBYTES_W:0]     ibytes_sum;
    logic [IBYTES_W-1:0]   ibytes_sat;
    logic [IFRAMES_W-1:0]  iframes_sat;
    logic [TBYTES_W:0]     tbytes_sum;
    logic [TFRAMES_W:0]    tframes_sum;
    logic [TBYTES_W-1:0]   tbytes_sat;
    logic [TFRAMES_W-1:0]  tframes_sat;
    logic                  last_idx;

    // bin bounds, clamped, with fixed top bound on bins without a register
    always_comb
    begin
        for (int i = 0; i < BIN_COUNT; i++)
        begin
            if (i >= BIN_COUNT - 1 || i >= LIMIT_REGS)
            begin
                upper[i] = LAST_LIMIT;
            end
            else if (limit_reg[(i < LIMIT_REGS) ? i : 0] > LAST_LIMIT)
            begin
                upper[i] = LAST_LIMIT;
            end
            else
            begin
                upper[i] = limit_reg[(i < LIMIT_REGS) ? i : 0];
            end
        end
    end

    // first bin whose bound covers the size
    always_comb
    begin
        bin_next = IDX_W'(BIN_COUNT - 1);
        for (int i = BIN_COUNT - 2; i >= 0; i--)
        begin
            if ({1'b0, upper[i]} >= size_reg)
            begin
                bin_next = IDX_W'(i);
            end
        end
    end

    assign ptr        = cmd.fold ? idx_reg : bin_reg;
    assign ibytes_rd  = ibytes_reg[ptr];
    assign iframes_rd = iframes_reg[ptr];

    assign ibytes_sum  = {1'b0, ibytes_rd} + (IBYTES_W + 1)'(size_reg);
    assign ibytes_sat  = ibytes_sum[IBYTES_W] ? '1 : ibytes_sum[IBYTES_W-1:0];
    assign iframes_sat = (&iframes_rd) ? iframes_rd : iframes_rd + 1'b1;

    assign tbytes_sum  = {1'b0, tbytes_reg[idx_reg]} + (TBYTES_W + 1)'(ibytes_rd);
    assign tframes_sum = {1'b0, tframes_reg[idx_reg]} + (TFRAMES_W + 1)'(iframes_rd);
    assign tbytes_sat  = tbytes_sum[TBYTES_W] ? '1 : tbytes_sum[TBYTES_W-1:0];
    assign tframes_sat = tframes_sum[TFRAMES_W] ? '1 : tframes_sum[TFRAMES_W-1:0];

    assign last_idx = (idx_reg == IDX_W'(BIN_COUNT - 1));

    assign status.out_busy = out_valid_reg && out_stall;
    assign status.last_idx = last_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIMIT_REGS; i++)
            begin
                limit_reg[i] <= LIMIT_RESET[i];
            end
        end
        else if (cfg_write && cfg_index < CFG_IDX_W'(LIMIT_REGS))
        begin
            limit_reg[cfg_index] <= cfg_data;
        end
    end

    // frame size and bin selection
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            size_reg <= {1'b0, frame_length} + FRAME_OVERHEAD;
        end
        if (cmd.classify)
        begin
            bin_reg <= bin_next;
        end
    end

    // report walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            lower_reg <= '0;
        end
        else if (cmd.idx_clear)
        begin
            idx_reg   <= '0;
            lower_reg <= '0;
        end
        else if (cmd.fold)
        begin
            idx_reg   <= last_idx ? '0 : idx_reg + 1'b1;
            lower_reg <= upper[idx_reg] + 1'b1;
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                ibytes_reg[i]  <= '0;
                iframes_reg[i] <= '0;
                tbytes_reg[i]  <= '0;
                tframes_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            ibytes_reg[ptr]  <= ibytes_sat;
            iframes_reg[ptr] <= iframes_sat;
        end
        else if (cmd.fold)
        begin
            ibytes_reg[ptr]      <= '0;
            iframes_reg[ptr]     <= '0;
            tbytes_reg[idx_reg]  <= tbytes_sat;
            tframes_reg[idx_reg] <= tframes_sat;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fold)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fold)
        begin
            out_bin_reg     <= BIN_NUM_W'(idx_reg);
            out_lower_reg   <= lower_reg;
            out_upper_reg   <= upper[idx_reg];
            out_ibytes_reg  <= ibytes_rd;
            out_iframes_reg <= iframes_rd;
            out_tbytes_reg  <= tbytes_sat;
            out_tframes_reg <= tframes_sat;
            out_last_reg    <= last_idx;
        end
    end

    assign out_valid            = out_valid_reg;
    assign bin_number           = out_bin_reg;
    assign lower_bound          = out_lower_reg;
    assign upper_bound          = out_upper_reg;
    assign interval_byte_count  = out_ibytes_reg;
    assign interval_frame_count = out_iframes_reg;
    assign total_byte_count     = out_tbytes_reg;
    assign total_frame_count    = out_tframes_reg;
    assign last_bin             = out_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |-> !(out_valid_reg && out_stall))
        else $error("output word overwritten while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |=> out_valid_reg)
        else $error("folded bin not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fold && !last_idx) |=> idx_reg == $past(idx_reg) + 1'b1)
        else $error("report walk skipped a bin");
`endif

endmodule

`default_nettype wire

// ===== sv/frame_size_histogram_core.sv =====
`default_nettype none

// Ethernet frame-size histogram. Each word with func 0 adds 26 bytes of layer-2
// overhead to frame_length, picks the first bin whose upper bound covers that size
// (the last bin otherwise) and adds the size and one frame to that bin's saturating
// interval counters; it passes through accept, classify and counter update in turn.
// func 1 and 3 are dropped. func 2 starts a report: each bin in turn folds its
// interval counts into its saturating totals, emits one output word and clears its
// interval counts, one bin per cycle while the output side keeps up; the walk pauses
// whenever the output word register is stalled. The next input word is taken as
// soon as the walk has loaded the last bin, even while that word still waits on the
// output. Bin limits 0..6 are written through the cfg port; the user must write them
// only while the block is idle, the block itself does not enforce this. Values above
// 9999 act as 9999, and the last bin always ends at 9999.
module frame_size_histogram_core
    import fhist_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [LIMIT_W-1:0]    cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [LIMIT_W-1:0]    frame_length,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BIN_NUM_W-1:0]       bin_number,
    output logic [LIMIT_W-1:0]         lower_bound,
    output logic [LIMIT_W-1:0]         upper_bound,
    output logic [IBYTES_W-1:0]        interval_byte_count,
    output logic [IFRAMES_W-1:0]       interval_frame_count,
    output logic [TBYTES_W-1:0]        total_byte_count,
    output logic [TFRAMES_W-1:0]       total_frame_count,
    output logic                       last_bin
);

    fhist_cmd_t    cmd;
    fhist_status_t status;

    fhist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fhist_datapath #(
        .BIN_COUNT (BIN_COUNT)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .frame_length         (frame_length),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .bin_number           (bin_number),
        .lower_bound          (lower_bound),
        .upper_bound          (upper_bound),
        .interval_byte_count  (interval_byte_count),
        .interval_frame_count (interval_frame_count),
        .total_byte_count     (total_byte_count),
        .total_frame_count    (total_frame_count),
        .last_bin             (last_bin)
    );

endmodule

`default_nettype wire

// ===== tb/frame_size_histogram_core_tb.sv =====
`default_nettype none

module frame_size_histogram_core_tb
    import fhist_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS          = BIN_COUNT_DEF;
    localparam int PHASES         = 6;
    localparam int WORDS_PER_PH   = 50;
    localparam int IDLE_LIMIT     = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 12;
    localparam int MAX_SHOWN      = 10;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 3'd7;

    typedef struct packed {
        logic [BIN_NUM_W-1:0] bin;
        logic [LIMIT_W-1:0]   lo;
        logic [LIMIT_W-1:0]   hi;
        logic [IBYTES_W-1:0]  ib;
        logic [IFRAMES_W-1:0] ifr;
        logic [TBYTES_W-1:0]  tb;
        logic [TFRAMES_W-1:0] tf;
        logic                 last;
    } bin_report_t;

    typedef struct packed {
        func_t                fn;
        logic [LIMIT_W-1:0]   len;
        logic                 typed;
        logic [BIN_NUM_W-1:0] t_bin;
        logic [IBYTES_W-1:0]  t_bytes;
        logic [IFRAMES_W-1:0] t_frames;
    } dir_row_t;

    localparam int DIR_N = 20;

    // typed values: empty after reset, bin 7 after the oversize frames, cleared again
    dir_row_t dir_rows [DIR_N] = '{
        '{FN_REPORT, 14'd0,     1'b1, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd0,     1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd34,    1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd35,    1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd74,    1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd75,    1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd1174,  1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd1175,  1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd9973,  1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd16383, 1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_STATUS, 14'd16383, 1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_SPARE,  14'd0,     1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_SPARE,  14'd16383, 1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_REPORT, 14'd0,     1'b1, 3'd7, 32'd27609, 24'd3},
        '{FN_REPORT, 14'd16383, 1'b1, 3'd7, 32'd0,     24'd0},
        '{FN_FRAME,  14'd8191,  1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd5461,  1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_FRAME,  14'd10922, 1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_STATUS, 14'd0,     1'b0, 3'd0, 32'd0,     24'd0},
        '{FN_REPORT, 14'd5461,  1'b0, 3'd0, 32'd0,     24'd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [LIMIT_W-1:0]    cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [FUNC_W-1:0]     func;
    logic [LIMIT_W-1:0]    frame_length;
    logic                  out_valid;
    logic                  out_stall;
    logic [BIN_NUM_W-1:0]  bin_number;
    logic [LIMIT_W-1:0]    lower_bound;
    logic [LIMIT_W-1:0]    upper_bound;
    logic [IBYTES_W-1:0]   interval_byte_count;
    logic [IFRAMES_W-1:0]  interval_frame_count;
    logic [TBYTES_W-1:0]   total_byte_count;
    logic [TFRAMES_W-1:0]  total_frame_count;
    logic                  last_bin;

    // histogram state as the block should hold it
    logic [LIMIT_W-1:0]    cur_limit [LIMIT_REGS];
    logic [IBYTES_W-1:0]   ibytes    [NBINS];
    logic [IFRAMES_W-1:0]  iframes   [NBINS];
    logic [TBYTES_W-1:0]   tbytes    [NBINS];
    logic [TFRAMES_W-1:0]  tframes   [NBINS];

    bin_report_t bin_reports_due [$];

    int words_in;
    int reports_in;
    int bins_checked;
    int mismatches;
    int settings_used;
    int idle_cycles;
    int burst_left;
    bit hold_req;
    bit hold_done;

    frame_size_histogram_core DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .func                 (func),
        .frame_length         (frame_length),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .bin_number           (bin_number),
        .lower_bound          (lower_bound),
        .upper_bound          (upper_bound),
        .interval_byte_count  (interval_byte_count),
        .interval_frame_count (interval_frame_count),
        .total_byte_count     (total_byte_count),
        .total_frame_count    (total_frame_count),
        .last_bin             (last_bin)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int bound_of(input int b);
        if (b >= LIMIT_REGS)
            return int'(LAST_LIMIT);
        return (cur_limit[b] > LAST_LIMIT) ? int'(LAST_LIMIT) : int'(cur_limit[b]);
    endfunction

    task automatic count_word(input func_t fn, input logic [LIMIT_W-1:0] len);
        int size;
        int b;
        logic [IBYTES_W:0]  sb;
        logic [IFRAMES_W:0] sf;
        logic [TBYTES_W:0]  st;
        logic [TFRAMES_W:0] sn;
        bin_report_t r;
        size = int'(len) + int'(FRAME_OVERHEAD);
        if (fn == FN_FRAME)
        begin
            b = NBINS - 1;
            for (int i = NBINS - 2; i >= 0; i--)
                if (bound_of(i) >= size)
                    b = i;
            sb = {1'b0, ibytes[b]} + (IBYTES_W+1)'(size);
            ibytes[b] = sb[IBYTES_W] ? '1 : sb[IBYTES_W-1:0];
            sf = {1'b0, iframes[b]} + 1'b1;
            iframes[b] = sf[IFRAMES_W] ? '1 : sf[IFRAMES_W-1:0];
        end
        else if (fn == FN_REPORT)
        begin
            for (int i = 0; i < NBINS; i++)
            begin
                st = {1'b0, tbytes[i]} + (TBYTES_W+1)'(ibytes[i]);
                tbytes[i] = st[TBYTES_W] ? '1 : st[TBYTES_W-1:0];
                sn = {1'b0, tframes[i]} + (TFRAMES_W+1)'(iframes[i]);
                tframes[i] = sn[TFRAMES_W] ? '1 : sn[TFRAMES_W-1:0];
                r.bin  = BIN_NUM_W'(i);
                r.lo   = (i == 0) ? '0 : LIMIT_W'(bound_of(i - 1) + 1);
                r.hi   = LIMIT_W'(bound_of(i));
                r.ib   = ibytes[i];
                r.ifr  = iframes[i];
                r.tb   = tbytes[i];
                r.tf   = tframes[i];
                r.last = (i == NBINS - 1);
                bin_reports_due.push_back(r);
                ibytes[i]  = '0;
                iframes[i] = '0;
            end
        end
    endtask

    task automatic show_mismatch(input bin_report_t want, input bin_report_t got,
                                 input bit orphan);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
        begin
            if (orphan)
                $display("unexpected word: bin %0d lo %0d hi %0d ib %0d if %0d tb %0d tf %0d last %0b",
                         got.bin, got.lo, got.hi, got.ib, got.ifr, got.tb, got.tf, got.last);
            else
            begin
                $display("mismatch: expected bin %0d lo %0d hi %0d ib %0d if %0d tb %0d tf %0d last %0b",
                         want.bin, want.lo, want.hi, want.ib, want.ifr, want.tb, want.tf,
                         want.last);
                $display("          actual   bin %0d lo %0d hi %0d ib %0d if %0d tb %0d tf %0d last %0b",
                         got.bin, got.lo, got.hi, got.ib, got.ifr, got.tb, got.tf, got.last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        bin_report_t got;
        bin_report_t want;
        int idx;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {bin_number, lower_bound, upper_bound, interval_byte_count,
                       interval_frame_count, total_byte_count, total_frame_count, last_bin};
                if (bin_reports_due.size() == 0)
                    show_mismatch(got, got, 1'b1);
                else
                begin
                    want = bin_reports_due.pop_front();
                    bins_checked++;
                    if (got !== want)
                        show_mismatch(want, got, 1'b0);
                end
            end
            if (in_valid && !in_stall)
            begin
                count_word(func_t'(func), frame_length);
                if (func_t'(func) == FN_REPORT)
                begin
                    reports_in++;
                    if (words_in < DIR_N && dir_rows[words_in].typed)
                    begin
                        idx = bin_reports_due.size() - NBINS + int'(dir_rows[words_in].t_bin);
                        want = bin_reports_due[idx];
                        want.ib  = dir_rows[words_in].t_bytes;
                        want.ifr = dir_rows[words_in].t_frames;
                        bin_reports_due[idx] = want;
                    end
                end
                words_in++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress, %0d bin words still due", bin_reports_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: changing stall pattern, plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int run_left;
        int hold_left;
        bit run_val;
        bit stall_next;
        mode = 0;
        mode_left = 0;
        run_left = 0;
        hold_left = 0;
        run_val = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done && hold_left == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                stall_next = 1'b1;
                hold_left--;
                if (hold_left == 0)
                    hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                case (mode)
                    0: stall_next = 1'b0;
                    1: stall_next = ($urandom_range(0, 2) == 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_val = ~run_val;
                            run_left = $urandom_range(1, 12);
                        end
                        run_left--;
                        stall_next = run_val;
                    end
                endcase
            end
            out_stall = stall_next;
        end
    end

    task automatic put_word(input func_t fn, input logic [LIMIT_W-1:0] len, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        func = fn;
        frame_length = len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx < LIMIT_REGS)
            cur_limit[idx] = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic program_limits(input int ph);
        logic [LIMIT_W-1:0] vals [LIMIT_REGS];
        int v;
        v = 30 + $urandom_range(0, 40);
        for (int i = 0; i < LIMIT_REGS; i++)
        begin
            case (ph)
                2: vals[i] = '1;
                3: vals[i] = '0;
                4:
                begin
                    vals[i] = LIMIT_W'(v);
                    v += $urandom_range(1, 400);
                end
                default: vals[i] = LIMIT_W'($urandom_range(0, 16383));
            endcase
        end
        if (ph == 1)
        begin
            // non-ascending, zero, above 9999
            vals[0] = 14'd0;
            vals[1] = 14'd16383;
            vals[2] = 14'd5;
            vals[3] = 14'd9999;
            vals[4] = 14'd10000;
            vals[5] = 14'd100;
            vals[6] = 14'd0;
        end
        for (int i = 0; i < LIMIT_REGS; i++)
            write_limit(CFG_IDX_W'(i), vals[i]);
        if (ph == 1 || ph == 5)
            write_limit(SPARE_REG_IDX, LIMIT_W'($urandom_range(0, 16383)));
        settings_used++;
    endtask

    task automatic drain_and_settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (bin_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [LIMIT_W-1:0] pick_length();
        int t;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            t = bound_of($urandom_range(0, LIMIT_REGS - 1)) - int'(FRAME_OVERHEAD)
                + $urandom_range(0, 2) - 1;
            if (t < 0)
                t = 0;
            return LIMIT_W'(t);
        end
        if (sel < 6)
            return LIMIT_W'($urandom_range(0, 200));
        if (sel < 9)
            return LIMIT_W'($urandom_range(0, 16383));
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    function automatic func_t pick_func();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            return FN_FRAME;
        if (sel < 85)
            return FN_REPORT;
        if (sel < 93)
            return FN_STATUS;
        return FN_SPARE;
    endfunction

    function automatic int next_gap(input int ph);
        if (ph == 2)
            return 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            return $urandom_range(1, 6);
        end
        burst_left--;
        return 0;
    endfunction

    initial
    begin
        func_t fn;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FN_STATUS;
        frame_length = '0;
        words_in = 0;
        reports_in = 0;
        bins_checked = 0;
        mismatches = 0;
        settings_used = 1;
        idle_cycles = 0;
        burst_left = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        for (int i = 0; i < LIMIT_REGS; i++)
            cur_limit[i] = LIMIT_RESET[i];
        for (int i = 0; i < NBINS; i++)
        begin
            ibytes[i] = '0;
            iframes[i] = '0;
            tbytes[i] = '0;
            tframes[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIR_N; r++)
            put_word(dir_rows[r].fn, dir_rows[r].len, (r % 4 == 3) ? 2 : 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_and_settle();
                program_limits(ph);
            end
            if (ph == 4)
                hold_req = 1'b1;
            for (int k = 0; k < WORDS_PER_PH; k++)
            begin
                fn = (ph == 4 && k == 0) ? FN_REPORT : pick_func();
                put_word(fn, pick_length(), next_gap(ph));
            end
            put_word(FN_REPORT, pick_length(), next_gap(ph));
        end
        drain_and_settle();

        $display("covered %0d input words with %0d reports, %0d bin words checked",
                 words_in, reports_in, bins_checked);
        $display("over %0d bin limit settings incl. zero, non-ascending and above 9999",
                 settings_used);
        if (mismatches == 0 && bin_reports_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/fhist_pkg.sv
sv/fhist_ctrl.sv
sv/fhist_datapath.sv
sv/frame_size_histogram_core.sv
tb/frame_size_histogram_core_tb.sv
